// ===== src/mrrim_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrim_pkg: shared types and constants
// Op codes, the result record and the fixed field widths of the ring index
// manager.
// ----------------------------------------------------------------------------
package mrrim_pkg;

  localparam int SLOT_W = 4;   // width of a slot index
  localparam int CNT_W  = 5;   // width of the slot count register
  localparam int RD_W   = 2;   // width of the reader select field
  localparam int OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_PREPARE = 2'd1,
    OP_PUBLISH = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
    logic              notified;
  } res_t;

endpackage

// ===== src/multi_reader_ring_index_manager_top.sv =====
// ----------------------------------------------------------------------------
// multi_reader_ring_index_manager_top: ring buffer slot index manager
// One writer and up to NUM_READERS readers share an overwriting ring of
// slot indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one op per transfer:
//   op_i = read (reader_i selects the reader), prepare, publish or no-op.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   per op: slot_o, slot_valid_o and notified_o.
//   cfg_we_i writes the slot count (clamped to 1..min(MAX_SLOTS, 16)); write
//   it only while no op is in flight.
// Pipeline and throughput:
//   An op accepted into the input register is executed once the output
//   register can take its result; execution loads the result into the output
//   register, which presents it on the output. One op per cycle is sustained
//   while out_stall_i does not hold a full output register: the input register
//   and the output register each hold one transfer, and the state update for
//   an op is a single pass of compares and increments.
// Reset:
//   rst_ni (async, active low) empties both stages, idles all readers,
//   closes the write slot, sets newest slot and all pointers to 0 and the
//   slot count to its maximum.
// Stalls:
//   While out_stall_i holds a full output register, the queued op waits in
//   the input register and in_stall_o is raised; no result is dropped.
// ----------------------------------------------------------------------------
module multi_reader_ring_index_manager_top
  import mrrim_pkg::*;
#(
  parameter int NUM_READERS = 4,
  parameter int MAX_SLOTS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  // op input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [RD_W-1:0]   reader_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic              slot_valid_o,
  output logic              notified_o
);

  logic [CNT_W-1:0] slot_count;

  mrrim_cfg #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .slot_count_o(slot_count)
  );

  // Input stage
  logic            s1_valid_q;
  logic [OP_W-1:0] s1_op_q;
  logic [RD_W-1:0] s1_reader_q;

  // Output stage
  logic out_valid_q;
  res_t res_q, res_d;

  logic out_free;   // output register can take a new result this cycle
  logic fire;       // op in the input stage executes this cycle
  logic in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= op_i;
      s1_reader_q <= reader_i;
    end
  end

  mrrim_state #(
    .NUM_READERS(NUM_READERS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (op_e'(s1_op_q)),
    .reader_i    (s1_reader_q),
    .slot_count_i(slot_count),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_o       = res_q.slot;
  assign slot_valid_o = res_q.slot_valid;
  assign notified_o   = res_q.notified;

endmodule

// ===== src/mrrim_cfg.sv =====
// ----------------------------------------------------------------------------
// mrrim_cfg: slot count register
// Holds the number of ring slots in use, clamped to 1..min(MAX_SLOTS, 16).
// ----------------------------------------------------------------------------
module mrrim_cfg
  import mrrim_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output logic [CNT_W-1:0] slot_count_o
);

  localparam int SlotLimitInt = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
  localparam logic [CNT_W-1:0] SlotLimit = CNT_W'(SlotLimitInt);
  localparam logic [CNT_W-1:0] CountOne  = CNT_W'(1);

  logic [CNT_W-1:0] count_d, count_q;

  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      count_d = CountOne;
    end else if (cfg_wdata_i > SlotLimit) begin
      count_d = SlotLimit;
    end else begin
      count_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= SlotLimit;
    end else if (cfg_we_i) begin
      count_q <= count_d;
    end
  end

  assign slot_count_o = count_q;

endmodule

// ===== src/mrrim_state.sv =====
// ----------------------------------------------------------------------------
// mrrim_state: writer and reader pointer state
// Applies one op per cycle, on cycles with fire_i high, to the writer slot,
// newest slot and reader pointers, and forms the result of that op.
// ----------------------------------------------------------------------------
module mrrim_state
  import mrrim_pkg::*;
#(
  parameter int NUM_READERS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,       // op in the input stage is executed
  input  op_e              op_i,
  input  logic [RD_W-1:0]  reader_i,
  input  logic [CNT_W-1:0] slot_count_i,
  output res_t             res_o
);

  logic [SLOT_W-1:0] pos_q    [NUM_READERS];
  logic [SLOT_W-1:0] pos_d    [NUM_READERS];
  logic [NUM_READERS-1:0] active_q, active_d;
  logic [SLOT_W-1:0] wpos_q, wpos_d;
  logic              wopen_q, wopen_d;
  logic [SLOT_W-1:0] newest_q, newest_d;

  // Increment with wrap at the slot count; indices past the count wrap too.
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  cnt);
    logic [CNT_W-1:0] n;
    n = {1'b0, idx} + CNT_W'(1);
    return (n >= cnt) ? '0 : n[SLOT_W-1:0];
  endfunction

  logic [SLOT_W-1:0] wnext;

  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    wpos_d   = wpos_q;
    wopen_d  = wopen_q;
    newest_d = newest_q;
    res_o    = '0;
    wnext    = next_slot(newest_q, slot_count_i);

    unique case (op_i)
      OP_READ: begin
        for (int i = 0; i < NUM_READERS; i++) begin
          if ((32'(reader_i) == i) && active_q[i]) begin
            res_o.slot       = pos_q[i];
            res_o.slot_valid = 1'b1;
            if (pos_q[i] == newest_q) begin
              active_d[i] = 1'b0;
            end else begin
              pos_d[i] = next_slot(pos_q[i], slot_count_i);
            end
          end
        end
      end
      OP_PREPARE: begin
        res_o.slot_valid = 1'b1;
        if (!wopen_q) begin
          wpos_d     = wnext;
          wopen_d    = 1'b1;
          res_o.slot = wnext;
          // overwrite on overflow: push readers off the slot being opened
          for (int i = 0; i < NUM_READERS; i++) begin
            if (active_q[i] && (pos_q[i] == wnext)) begin
              pos_d[i] = next_slot(wnext, slot_count_i);
            end
          end
        end else begin
          res_o.slot = wpos_q;
        end
      end
      OP_PUBLISH: begin
        if (wopen_q) begin
          wopen_d = 1'b0;
          if ({1'b0, wpos_q} < slot_count_i) begin
            newest_d       = wpos_q;
            res_o.notified = 1'b1;
            for (int i = 0; i < NUM_READERS; i++) begin
              if (!active_q[i]) begin
                active_d[i] = 1'b1;
                pos_d[i]    = wpos_q;
              end
            end
          end
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_READERS; i++) begin
        pos_q[i] <= '0;
      end
      active_q <= '0;
      wpos_q   <= '0;
      wopen_q  <= 1'b0;
      newest_q <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      active_q <= active_d;
      wpos_q   <= wpos_d;
      wopen_q  <= wopen_d;
      newest_q <= newest_d;
    end
  end

endmodule
